>>> rtl/ubsr_pkg.sv
`default_nettype none

package ubsr_pkg;

    // field widths
    localparam int HANDLE_W    = 64;
    localparam int SLOT_W      = 6;
    localparam int COUNT_W     = 7;
    localparam int IN_TDATA_W  = 64;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 80;
    localparam int OUT_TUSER_W = 3;

    // default store depth
    localparam int CAPACITY_DEF = 64;

    // command codes
    typedef enum logic [IN_TUSER_W-1:0] {
        CMD_ADD      = 2'd0,
        CMD_REMOVE   = 2'd1,
        CMD_SNAPSHOT = 2'd2
    } cmd_t;

    // result status codes
    typedef enum logic [OUT_TUSER_W-1:0] {
        ST_OK    = 3'd0,
        ST_ZERO  = 3'd1,
        ST_FULL  = 3'd2,
        ST_MISS  = 3'd3,
        ST_ENTRY = 3'd4,
        ST_EMPTY = 3'd5
    } status_t;

endpackage

`default_nettype wire

>>> rtl/ubsr_mem.sv
`default_nettype none

module ubsr_mem #(
    parameter int DEPTH  = ubsr_pkg::CAPACITY_DEF,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic                          clk,
    input  wire logic                          we,
    input  wire logic [ADDR_W-1:0]             waddr,
    input  wire logic [ubsr_pkg::HANDLE_W-1:0] wdata,
    input  wire logic                          re,
    input  wire logic [ADDR_W-1:0]             raddr,
    output logic      [ubsr_pkg::HANDLE_W-1:0] rdata
);

    logic [ubsr_pkg::HANDLE_W-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port, data holds while no read is issued
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

>>> rtl/unordered_bag_swap_remove.sv
`default_nettype none

// Unordered bag of nonzero 64-bit handles with swap-remove.
// Input channel s_axis: tuser carries the command (add, remove, snapshot),
// tdata the handle. Output channel m_axis: tuser carries the status, tdata
// the entry, slot and held count, tlast marks the final result of a command.
// Handles live in a single-port-read, single-port-write synchronous memory
// of CAPACITY entries; the held count sits in a register.
// Order: an add, a zero handle or an empty snapshot goes through S_EMIT into the
// output register. A remove scans the memory one entry per cycle, one read in
// flight; a hit is followed by one tail read and one write back. A snapshot
// streams one entry per cycle from the memory read port while the receiver
// keeps up, its first read issued when the transaction is accepted.
// One command is worked on at a time; s_axis_tready is high only when idle,
// which includes while a finished result waits in the output register.
// Reset clears the held count and the output register; the memory is not
// cleared, since only slots below the count are ever read.
// When the receiver stalls, the output register holds its transaction and
// the snapshot or the pending result waits, with no result lost or repeated.
module unordered_bag_swap_remove #(
    parameter int CAPACITY = ubsr_pkg::CAPACITY_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    // input transaction
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  wire logic [ubsr_pkg::IN_TDATA_W-1:0]  s_axis_tdata,  // handle[63:0]
    input  wire logic [ubsr_pkg::IN_TUSER_W-1:0]  s_axis_tuser,  // cmd[1:0]
    // output transaction
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    output logic      [ubsr_pkg::OUT_TDATA_W-1:0] m_axis_tdata,  // entry[63:0], slot[69:64],
                                                                 // held[76:70], zero pad
    output logic      [ubsr_pkg::OUT_TUSER_W-1:0] m_axis_tuser,  // status[2:0]
    output logic                                  m_axis_tlast
);

    localparam int ADDR_W = $clog2(CAPACITY);
    localparam logic [ubsr_pkg::COUNT_W-1:0] CAP_CNT = ubsr_pkg::COUNT_W'(CAPACITY);
    localparam int PAD_W = ubsr_pkg::OUT_TDATA_W - ubsr_pkg::HANDLE_W
                           - ubsr_pkg::SLOT_W - ubsr_pkg::COUNT_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_MOVE,
        S_EMIT,
        S_SNAP
    } state_t;

    state_t                          state_reg, state_next;
    logic [ubsr_pkg::COUNT_W-1:0]    count_reg, count_next;
    logic [ubsr_pkg::HANDLE_W-1:0]   handle_reg, handle_next;
    ubsr_pkg::status_t               status_reg, status_next;
    logic [ADDR_W-1:0]               slot_reg, slot_next;
    logic [ubsr_pkg::COUNT_W-1:0]    issue_reg, issue_next;
    logic                            cmp_vld_reg, cmp_vld_next;
    logic [ADDR_W-1:0]               cmp_idx_reg, cmp_idx_next;
    logic [ADDR_W-1:0]               snap_idx_reg, snap_idx_next;
    logic                            out_valid_reg, out_valid_next;
    ubsr_pkg::status_t               out_status_reg, out_status_next;
    logic [ubsr_pkg::HANDLE_W-1:0]   out_entry_reg, out_entry_next;
    logic [ubsr_pkg::SLOT_W-1:0]     out_slot_reg, out_slot_next;
    logic [ubsr_pkg::COUNT_W-1:0]    out_held_reg, out_held_next;
    logic                            out_last_reg, out_last_next;

    logic                            mem_we;
    logic [ADDR_W-1:0]               mem_waddr;
    logic [ubsr_pkg::HANDLE_W-1:0]   mem_wdata;
    logic                            mem_re;
    logic [ADDR_W-1:0]               mem_raddr;
    logic [ubsr_pkg::HANDLE_W-1:0]   mem_rdata;

    logic                            out_free;
    logic [ubsr_pkg::HANDLE_W-1:0]   in_handle;
    logic [ubsr_pkg::COUNT_W-1:0]    snap_pos;
    logic [ubsr_pkg::COUNT_W-1:0]    tail_pos;

    // handle store
    ubsr_mem #(
        .DEPTH  (CAPACITY),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign in_handle = s_axis_tdata[ubsr_pkg::HANDLE_W-1:0];
    assign out_free  = !out_valid_reg || m_axis_tready;
    assign snap_pos  = ubsr_pkg::COUNT_W'(snap_idx_reg) + 1'b1;
    assign tail_pos  = count_reg - 1'b1;

    // command sequencer
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        handle_next     = handle_reg;
        status_next     = status_reg;
        slot_next       = slot_reg;
        issue_next      = issue_reg;
        cmp_vld_next    = cmp_vld_reg;
        cmp_idx_next    = cmp_idx_reg;
        snap_idx_next   = snap_idx_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_entry_next  = out_entry_reg;
        out_slot_next   = out_slot_reg;
        out_held_next   = out_held_reg;
        out_last_next   = out_last_reg;
        mem_we          = 1'b0;
        mem_waddr       = count_reg[ADDR_W-1:0];
        mem_wdata       = in_handle;
        mem_re          = 1'b0;
        mem_raddr       = issue_reg[ADDR_W-1:0];

        // output register drains on a taken transaction
        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    handle_next = in_handle;
                    slot_next   = '0;
                    unique case (ubsr_pkg::cmd_t'(s_axis_tuser))
                        ubsr_pkg::CMD_ADD:
                        begin
                            state_next = S_EMIT;
                            if (in_handle == '0)
                            begin
                                status_next = ubsr_pkg::ST_ZERO;
                            end
                            else if (count_reg >= CAP_CNT)
                            begin
                                status_next = ubsr_pkg::ST_FULL;
                            end
                            else
                            begin
                                mem_we      = 1'b1;
                                count_next  = count_reg + 1'b1;
                                status_next = ubsr_pkg::ST_OK;
                                slot_next   = count_reg[ADDR_W-1:0];
                            end
                        end
                        ubsr_pkg::CMD_REMOVE:
                        begin
                            if (in_handle == '0)
                            begin
                                status_next = ubsr_pkg::ST_ZERO;
                                state_next  = S_EMIT;
                            end
                            else
                            begin
                                issue_next   = '0;
                                cmp_vld_next = 1'b0;
                                state_next   = S_SCAN;
                            end
                        end
                        ubsr_pkg::CMD_SNAPSHOT:
                        begin
                            if (count_reg == '0)
                            begin
                                handle_next = '0;
                                status_next = ubsr_pkg::ST_EMPTY;
                                state_next  = S_EMIT;
                            end
                            else
                            begin
                                mem_re        = 1'b1;
                                mem_raddr     = '0;
                                snap_idx_next = '0;
                                state_next    = S_SNAP;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            // one read issued per cycle, each compared in the cycle after its issue
            S_SCAN:
            begin
                if (cmp_vld_reg && (mem_rdata == handle_reg))
                begin
                    mem_re       = 1'b1;
                    mem_raddr    = tail_pos[ADDR_W-1:0];
                    slot_next    = cmp_idx_reg;
                    cmp_vld_next = 1'b0;
                    state_next   = S_MOVE;
                end
                else if (issue_reg < count_reg)
                begin
                    mem_re       = 1'b1;
                    issue_next   = issue_reg + 1'b1;
                    cmp_vld_next = 1'b1;
                    cmp_idx_next = issue_reg[ADDR_W-1:0];
                end
                else
                begin
                    cmp_vld_next = 1'b0;
                    if (!cmp_vld_reg)
                    begin
                        status_next = ubsr_pkg::ST_MISS;
                        slot_next   = '0;
                        state_next  = S_EMIT;
                    end
                end
            end

            // tail entry moves into the vacated slot
            S_MOVE:
            begin
                mem_we      = 1'b1;
                mem_waddr   = slot_reg;
                mem_wdata   = mem_rdata;
                count_next  = tail_pos;
                status_next = ubsr_pkg::ST_OK;
                state_next  = S_EMIT;
            end

            // single result into the output register
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = status_reg;
                    out_entry_next  = handle_reg;
                    out_slot_next   = ubsr_pkg::SLOT_W'(slot_reg);
                    out_held_next   = count_reg;
                    out_last_next   = 1'b1;
                    state_next      = S_IDLE;
                end
            end

            // stream entries, next read issued as each one enters the output register
            S_SNAP:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = ubsr_pkg::ST_ENTRY;
                    out_entry_next  = mem_rdata;
                    out_slot_next   = ubsr_pkg::SLOT_W'(snap_idx_reg);
                    out_held_next   = count_reg;
                    out_last_next   = (snap_pos == count_reg);
                    if (snap_pos == count_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        mem_re        = 1'b1;
                        mem_raddr     = snap_pos[ADDR_W-1:0];
                        snap_idx_next = snap_pos[ADDR_W-1:0];
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            handle_reg     <= '0;
            status_reg     <= ubsr_pkg::ST_OK;
            slot_reg       <= '0;
            issue_reg      <= '0;
            cmp_vld_reg    <= 1'b0;
            cmp_idx_reg    <= '0;
            snap_idx_reg   <= '0;
            out_valid_reg  <= 1'b0;
            out_status_reg <= ubsr_pkg::ST_OK;
            out_entry_reg  <= '0;
            out_slot_reg   <= '0;
            out_held_reg   <= '0;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            handle_reg     <= handle_next;
            status_reg     <= status_next;
            slot_reg       <= slot_next;
            issue_reg      <= issue_next;
            cmp_vld_reg    <= cmp_vld_next;
            cmp_idx_reg    <= cmp_idx_next;
            snap_idx_reg   <= snap_idx_next;
            out_valid_reg  <= out_valid_next;
            out_status_reg <= out_status_next;
            out_entry_reg  <= out_entry_next;
            out_slot_reg   <= out_slot_next;
            out_held_reg   <= out_held_next;
            out_last_reg   <= out_last_next;
        end
    end

    // port drive
    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{PAD_W{1'b0}}, out_held_reg, out_slot_reg, out_entry_reg};
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

`default_nettype wire

>>> dv/unordered_bag_swap_remove_tb.sv
`default_nettype none

module unordered_bag_swap_remove_tb;

    localparam int          BAG_CAP      = ubsr_pkg::CAPACITY_DEF;
    localparam int          ITEM_TARGET  = 480;
    localparam int          QUIET_LIMIT  = 4000;
    localparam int          LONG_HOLD    = 300;
    localparam int          DRAIN_CYCLES = 80;
    localparam logic [1:0]  CMD_UNUSED   = 2'd3;

    // one result transaction as predicted
    typedef struct {
        ubsr_pkg::status_t status;
        logic [63:0]       entry;
        logic [5:0]        slot;
        logic [6:0]        held;
        logic              last;
    } bag_result_t;

    // mirror of the bag contents plus the results still owed by the block
    class bag_mirror;
        logic [63:0]  held_handles [BAG_CAP];
        int unsigned  held_count;
        bag_result_t  owed_results [$];
        int unsigned  errors;

        function new();
            held_count = 0;
            errors     = 0;
        endfunction

        function void owe(ubsr_pkg::status_t st, logic [63:0] e, int unsigned s,
                          int unsigned h, logic l);
            bag_result_t r;
            r.status = st;
            r.entry  = e;
            r.slot   = s[5:0];
            r.held   = h[6:0];
            r.last   = l;
            owed_results = {owed_results, r};
        endfunction

        // apply one accepted command and queue the results it causes
        function void apply_command(logic [1:0] cmd, logic [63:0] handle);
            int          i;
            int          hit;
            int unsigned tail;
            hit = -1;
            case (cmd)
                ubsr_pkg::CMD_ADD:
                begin
                    if (handle == '0)
                        owe(ubsr_pkg::ST_ZERO, handle, 0, held_count, 1'b1);
                    else if (held_count >= BAG_CAP)
                        owe(ubsr_pkg::ST_FULL, handle, 0, held_count, 1'b1);
                    else
                    begin
                        held_handles[held_count] = handle;
                        held_count++;
                        owe(ubsr_pkg::ST_OK, handle, held_count - 1, held_count, 1'b1);
                    end
                end
                ubsr_pkg::CMD_REMOVE:
                begin
                    if (handle == '0)
                        owe(ubsr_pkg::ST_ZERO, handle, 0, held_count, 1'b1);
                    else
                    begin
                        for (i = 0; i < held_count; i++)
                        begin
                            if (hit < 0 && held_handles[i] == handle)
                                hit = i;
                        end
                        if (hit < 0)
                            owe(ubsr_pkg::ST_MISS, handle, 0, held_count, 1'b1);
                        else
                        begin
                            // swap the last held handle into the vacated slot
                            tail = held_count - 1;
                            held_handles[hit] = held_handles[tail];
                            held_count = tail;
                            owe(ubsr_pkg::ST_OK, handle, hit, held_count, 1'b1);
                        end
                    end
                end
                ubsr_pkg::CMD_SNAPSHOT:
                begin
                    if (held_count == 0)
                        owe(ubsr_pkg::ST_EMPTY, '0, 0, 0, 1'b1);
                    else
                        for (i = 0; i < held_count; i++)
                            owe(ubsr_pkg::ST_ENTRY, held_handles[i], i, held_count,
                                (i + 1 == held_count));
                end
                default:
                begin
                    // unused command, no result
                end
            endcase
        endfunction

        // compare one accepted result with the oldest owed one
        function void check_result(logic [2:0] st, logic [63:0] e, logic [5:0] s,
                                   logic [6:0] h, logic l);
            bag_result_t r;
            if (owed_results.size() == 0)
            begin
                $error("result with nothing pending: status %0d entry %h", st, e);
                errors++;
                return;
            end
            r = owed_results.pop_front();
            if (st !== r.status)
            begin
                $error("status: expected %0d, actual %0d", r.status, st);
                errors++;
            end
            if (e !== r.entry)
            begin
                $error("entry: expected %h, actual %h", r.entry, e);
                errors++;
            end
            if (s !== r.slot)
            begin
                $error("slot: expected %0d, actual %0d", r.slot, s);
                errors++;
            end
            if (h !== r.held)
            begin
                $error("held: expected %0d, actual %0d", r.held, h);
                errors++;
            end
            if (l !== r.last)
            begin
                $error("last: expected %0d, actual %0d", r.last, l);
                errors++;
            end
        endfunction

        function int unsigned outstanding();
            return owed_results.size();
        endfunction
    endclass

    logic                              clk;
    logic                              rst_n;
    logic                              s_axis_tvalid;
    logic                              s_axis_tready;
    logic [ubsr_pkg::IN_TDATA_W-1:0]   s_axis_tdata;
    logic [ubsr_pkg::IN_TUSER_W-1:0]   s_axis_tuser;
    logic                              m_axis_tvalid;
    logic                              m_axis_tready;
    logic [ubsr_pkg::OUT_TDATA_W-1:0]  m_axis_tdata;
    logic [ubsr_pkg::OUT_TUSER_W-1:0]  m_axis_tuser;
    logic                              m_axis_tlast;

    bag_mirror   mirror = new();
    int          items_sent;
    bit          send_burst;
    bit          recv_burst;
    bit          hold_request;
    int          quiet_cycles;

    unordered_bag_swap_remove #(
        .CAPACITY (BAG_CAP)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // monitors on both channels
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
                mirror.check_result(m_axis_tuser, m_axis_tdata[63:0], m_axis_tdata[69:64],
                                    m_axis_tdata[76:70], m_axis_tlast);
            if (s_axis_tvalid && s_axis_tready)
                mirror.apply_command(s_axis_tuser, s_axis_tdata);
        end
    end

    // watchdog on cycles with no transaction on either side
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("** unordered_bag_swap_remove: FAILED **");
            $finish;
        end
    end

    // receiver with random stalls and one long hold-off
    initial
    begin
        int gap;
        bit hold_done;
        hold_done     = 1'b0;
        m_axis_tready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            gap = recv_burst ? 0 : $urandom_range(0, 13);
            if (hold_request && !hold_done)
            begin
                gap       = LONG_HOLD;
                hold_done = 1'b1;
            end
            if (gap > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            m_axis_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_axis_tvalid);
            @(negedge clk);
        end
    end

    // offer one command and wait for its transaction; called at a falling edge
    task automatic send_item(input logic [1:0] cmd, input logic [63:0] handle);
        int gap;
        gap = send_burst ? 0 : $urandom_range(0, 13);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= handle;
        do
            @(posedge clk);
        while (!s_axis_tready);
        @(negedge clk);
        if (cmd != CMD_UNUSED)
            items_sent++;
    endtask

    function automatic logic [63:0] rand_handle();
        case ($urandom_range(0, 3))
            0:       return 64'($urandom_range(1, 255));
            1:       return 64'h1 << $urandom_range(0, 63);
            default: return {$urandom(), $urandom()};
        endcase
    endfunction

    // a handle currently in the bag, or a fresh one if the bag is empty
    function automatic logic [63:0] held_pick();
        if (mirror.held_count == 0)
            return rand_handle();
        return mirror.held_handles[$urandom_range(0, mirror.held_count - 1)];
    endfunction

    // random mix, mostly adds and hitting removes
    task automatic run_mix(input int n);
        int r;
        repeat (n)
        begin
            r = $urandom_range(0, 99);
            if (r < 4)
                send_item(CMD_UNUSED, rand_handle());
            else if (r < 9)
                send_item(($urandom_range(0, 1) != 0) ? ubsr_pkg::CMD_ADD
                                                      : ubsr_pkg::CMD_REMOVE, '0);
            else if (r < 18)
                send_item(ubsr_pkg::CMD_SNAPSHOT, rand_handle());
            else if (r < 55)
                send_item(ubsr_pkg::CMD_ADD,
                          ($urandom_range(0, 6) == 0) ? held_pick() : rand_handle());
            else if (r < 85 && mirror.held_count > 0)
                send_item(ubsr_pkg::CMD_REMOVE, held_pick());
            else if (r < 92 && mirror.held_count > 0)
                send_item(ubsr_pkg::CMD_REMOVE,
                          held_pick() ^ (64'h1 << $urandom_range(0, 63)));
            else
                send_item(ubsr_pkg::CMD_REMOVE, rand_handle());
        end
    endtask

    // fill to capacity, push past it, read it all out, trim at both ends
    task automatic fill_bag();
        while (mirror.held_count < BAG_CAP)
            send_item(ubsr_pkg::CMD_ADD, rand_handle());
        repeat ($urandom_range(1, 3))
            send_item(ubsr_pkg::CMD_ADD, rand_handle());
        send_item(ubsr_pkg::CMD_SNAPSHOT, '0);
        send_item(ubsr_pkg::CMD_REMOVE, mirror.held_handles[BAG_CAP-1]);
        send_item(ubsr_pkg::CMD_REMOVE, mirror.held_handles[0]);
        send_item(ubsr_pkg::CMD_ADD, rand_handle());
        send_item(ubsr_pkg::CMD_SNAPSHOT, '0);
    endtask

    // remove everything in random order
    task automatic drain_bag();
        while (mirror.held_count > 0)
            send_item(ubsr_pkg::CMD_REMOVE, held_pick());
        send_item(ubsr_pkg::CMD_REMOVE, rand_handle());
        send_item(ubsr_pkg::CMD_SNAPSHOT, '0);
    endtask

    // stimulus
    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        items_sent    = 0;
        send_burst    = 1'b0;
        recv_burst    = 1'b0;
        hold_request  = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: empty bag, zero handles, unused command, extremes, swap
        send_item(ubsr_pkg::CMD_SNAPSHOT, '0);
        send_item(ubsr_pkg::CMD_REMOVE, 64'h5);
        send_item(ubsr_pkg::CMD_ADD, '0);
        send_item(ubsr_pkg::CMD_REMOVE, '0);
        send_item(CMD_UNUSED, '1);
        send_item(ubsr_pkg::CMD_ADD, 64'h1);
        send_item(ubsr_pkg::CMD_ADD, '1);
        send_item(ubsr_pkg::CMD_ADD, 64'h8000_0000_0000_0000);
        send_item(ubsr_pkg::CMD_ADD, 64'h1);
        send_item(ubsr_pkg::CMD_ADD, 64'hA5A5_5A5A_0F0F_F0F0);
        send_item(ubsr_pkg::CMD_SNAPSHOT, '0);
        send_item(ubsr_pkg::CMD_REMOVE, 64'h1);
        send_item(ubsr_pkg::CMD_REMOVE, 64'h2);
        send_item(ubsr_pkg::CMD_REMOVE, '1);
        send_item(ubsr_pkg::CMD_SNAPSHOT, '0);
        send_item(ubsr_pkg::CMD_REMOVE, 64'h1);
        send_item(ubsr_pkg::CMD_REMOVE, 64'hA5A5_5A5A_0F0F_F0F0);
        send_item(ubsr_pkg::CMD_REMOVE, 64'h8000_0000_0000_0000);
        send_item(ubsr_pkg::CMD_SNAPSHOT, '0);

        // fill once under a long receiver hold-off so the input backs up
        send_burst   = 1'b1;
        hold_request = 1'b1;
        fill_bag();
        send_burst   = 1'b0;
        drain_bag();

        // random episodes
        while (items_sent < ITEM_TARGET)
        begin
            send_burst = ($urandom_range(0, 3) == 0);
            recv_burst = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 9))
                8:       fill_bag();
                9:       drain_bag();
                default: run_mix(20);
            endcase
        end

        // wait for the last results, then a short tail
        s_axis_tvalid <= 1'b0;
        while (mirror.outstanding() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mirror.errors == 0)
            $display("** unordered_bag_swap_remove: PASSED **");
        else
            $display("** unordered_bag_swap_remove: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire
